@@ rtl/gfst_pkg.sv @@
// Grid formation slot table: shared types, codes and fixed field widths.
// No dependencies; compiled first.
package gfst_pkg;

    localparam int OP_W       = 2;
    localparam int RAD_W      = 16;
    localparam int GAP_W      = 16;
    localparam int APR_W      = 7;
    localparam int DIAM_W     = 17;
    localparam int SPACE_W    = 18;
    localparam int POS_W      = 25;
    localparam int GR_W       = 25;
    localparam int CNT_W      = 7;
    localparam int STAT_W     = 3;
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 64;
    localparam int DIG_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [APR_W-1:0] APR_RESET = 7'd4;
    localparam logic [GAP_W-1:0] GAP_RESET = 16'd256;

    localparam logic [POS_W-1:0] POS_MAX_C = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MIN_C = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [GR_W-1:0]  GR_MAX_C  = {GR_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_ADDED    = 3'd0,
        STAT_ALREADY  = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_REMOVED  = 3'd3,
        STAT_ABSENT   = 3'd4,
        STAT_POSITION = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AGENTS_PER_ROW = 1'b0,
        CFG_AGENT_GAP      = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_ROWS,
        ST_COL,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_W,
        ST_MUL_H,
        ST_MUL_WW,
        ST_MUL_HH,
        ST_SQRT,
        ST_OUT
    } fsm_t;

endpackage

@@ rtl/gfst_req_if.sv @@
// Request channel: operation, member id and radius with valid/ready.
// Depends on gfst_pkg.
interface gfst_req_if #(parameter int ID_BITS = 16);
    import gfst_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [ID_BITS-1:0]  agent_id;
    logic [RAD_W-1:0]    agent_radius;
    modport source (output valid, operation, agent_id, agent_radius, input ready);
    modport sink   (input valid, operation, agent_id, agent_radius, output ready);
endinterface

@@ rtl/gfst_rsp_if.sv @@
// Response channel: status, slot offset, group radius and member count.
// Depends on gfst_pkg.
interface gfst_rsp_if;
    import gfst_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [GR_W-1:0]          group_radius;
    logic [CNT_W-1:0]         member_count;
    modport source (output valid, status, pos_x, pos_y, group_radius, member_count,
                    input ready);
    modport sink   (input valid, status, pos_x, pos_y, group_radius, member_count,
                    output ready);
endinterface

@@ rtl/grid_formation_slot_table_unit.sv @@
// Grid formation slot table: ordered member list in a synchronous RAM with
// a sequencer, shared divider, multiplier and square-root units.
// Depends on gfst_pkg, gfst_req_if, gfst_rsp_if, gfst_mul, gfst_div, gfst_isqrt.
//
// One transaction is handled at a time. Each takes the id search through the
// member RAM (one read per cycle), a read and a write state per entry moved
// when a remove closes the gap, one division for the row count, four
// multiplications, a square root and the output register; a query of a present
// id adds a second division and two multiplications. A remove of the first
// member takes the longest. The result waits in an output register, so the
// next request is taken while it does.
module grid_formation_slot_table_unit #(
    parameter int MAX_MEMBERS = 64,
    parameter int ID_BITS     = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    gfst_req_if.sink                          req,
    gfst_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [gfst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gfst_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gfst_pkg::*;

    localparam int AW = $clog2(MAX_MEMBERS);
    localparam int CW = $clog2(MAX_MEMBERS + 1);
    localparam int DW = ((CW > APR_W) ? CW : APR_W) + 1;
    localparam int KW = CW + 2;
    localparam int YW = APR_W + 2;

    fsm_t                  state_reg, state_next;
    logic [OP_W-1:0]       op_reg;
    logic [ID_BITS-1:0]    id_reg;
    logic [RAD_W-1:0]      rad_reg;
    logic [CW-1:0]         total_reg;
    logic [DIAM_W-1:0]     diam_reg;
    logic [APR_W-1:0]      apr_reg;
    logic [GAP_W-1:0]      gap_reg;
    logic [CW-1:0]         scan_reg;
    logic                  cmp_v_reg;
    logic [AW-1:0]         cmp_addr_reg;
    logic                  found_reg;
    logic [AW-1:0]         idx_reg;
    logic [CW-1:0]         sh_reg;
    logic [ID_BITS-1:0]    rd_data_reg;
    status_t               status_reg;
    logic [CW-1:0]         rows_reg;
    logic [CW-1:0]         col_reg;
    logic [APR_W-1:0]      row_rem_reg;
    logic [POS_W-1:0]      px_reg;
    logic [POS_W-1:0]      py_reg;
    logic [MUL_W-1:0]      w_reg;
    logic [MUL_W-1:0]      h_reg;
    logic [PROD_W-1:0]     sq_reg;
    logic [PROD_W-1:0]     sum_reg;
    logic [GR_W-1:0]       gr_reg;

    logic                  rsp_valid_reg;
    logic [STAT_W-1:0]     rsp_status_reg;
    logic [POS_W-1:0]      rsp_px_reg;
    logic [POS_W-1:0]      rsp_py_reg;
    logic [GR_W-1:0]       rsp_gr_reg;
    logic [CNT_W-1:0]      rsp_cnt_reg;

    logic [ID_BITS-1:0]    mem [MAX_MEMBERS];
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [ID_BITS-1:0]    mem_wdata;
    logic [AW-1:0]         mem_raddr;

    logic                  div_start, div_busy, div_done;
    logic [DW-1:0]         div_dvd, div_q;
    logic [APR_W-1:0]      div_rem;
    logic                  mul_start, mul_busy, mul_done;
    logic [MUL_W-1:0]      mul_a, mul_b;
    logic [PROD_W-1:0]     mul_prod;
    logic                  sqrt_start, sqrt_busy, sqrt_done;
    logic [MUL_W-1:0]      sqrt_root;

    logic                  accept;
    logic                  issue;
    logic                  hit;
    logic                  search_end;
    logic [CW:0]           sh_inc;
    logic                  sh_more;
    logic                  add_ok;
    logic [DIAM_W-1:0]     rad2;
    logic [APR_W-1:0]      p_eff;
    logic [SPACE_W-1:0]    space;
    logic [DW-1:0]         rows_dvd;
    logic [KW-1:0]         kx, kx_abs;
    logic [YW-1:0]         ky, ky_abs;
    logic                  out_free;
    status_t               decide_status;

    function automatic logic [POS_W-1:0] sat_pos(input logic neg,
                                                 input logic [PROD_W-1:0] mag);
        logic [POS_W-1:0] r;
        if (neg)
            r = (mag > PROD_W'(POS_MIN_C)) ? POS_MIN_C : (~mag[POS_W-1:0] + 1'b1);
        else
            r = (mag > PROD_W'(POS_MAX_C)) ? POS_MAX_C : mag[POS_W-1:0];
        return r;
    endfunction

    assign accept     = req.valid && req.ready;
    assign issue      = scan_reg < total_reg;
    assign hit        = cmp_v_reg && (rd_data_reg == id_reg);
    assign search_end = !issue && !cmp_v_reg;
    assign sh_inc     = {1'b0, sh_reg} + (CW+1)'(1);
    assign sh_more    = sh_inc < {1'b0, total_reg};
    assign add_ok     = (op_reg == OP_ADD) && !found_reg && (total_reg < CW'(MAX_MEMBERS));
    assign rad2       = {rad_reg, 1'b0};
    assign p_eff      = (apr_reg == '0) ? APR_W'(1) : apr_reg;
    assign space      = SPACE_W'(gap_reg) + SPACE_W'(diam_reg);
    assign rows_dvd   = DW'(total_reg) + DW'(p_eff) - DW'(1);
    assign kx         = {2'b00, rows_reg} - KW'(1) - {1'b0, col_reg, 1'b0};
    assign kx_abs     = kx[KW-1] ? (KW'(0) - kx) : kx;
    assign ky         = {1'b0, row_rem_reg, 1'b0} - (YW'(p_eff) - YW'(1));
    assign ky_abs     = ky[YW-1] ? (YW'(0) - ky) : ky;
    assign out_free   = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        priority if (op_reg == OP_ADD)
            decide_status = found_reg ? STAT_ALREADY : (add_ok ? STAT_ADDED : STAT_FULL);
        else if (op_reg == OP_REMOVE)
            decide_status = found_reg ? STAT_REMOVED : STAT_ABSENT;
        else
            decide_status = found_reg ? STAT_POSITION : STAT_ABSENT;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (req.valid) state_next = ST_SEARCH;
            ST_SEARCH:   if (hit || search_end) state_next = ST_DECIDE;
            ST_DECIDE:   state_next = ((op_reg == OP_REMOVE) && found_reg) ? ST_SHIFT_RD
                                                                           : ST_ROWS;
            ST_SHIFT_RD: state_next = sh_more ? ST_SHIFT_WR : ST_ROWS;
            ST_SHIFT_WR: state_next = ST_SHIFT_RD;
            ST_ROWS:     if (div_done)
                             state_next = (status_reg == STAT_POSITION) ? ST_COL : ST_MUL_W;
            ST_COL:      if (div_done) state_next = ST_MUL_X;
            ST_MUL_X:    if (mul_done) state_next = ST_MUL_Y;
            ST_MUL_Y:    if (mul_done) state_next = ST_MUL_W;
            ST_MUL_W:    if (mul_done) state_next = ST_MUL_H;
            ST_MUL_H:    if (mul_done) state_next = ST_MUL_WW;
            ST_MUL_WW:   if (mul_done) state_next = ST_MUL_HH;
            ST_MUL_HH:   if (mul_done) state_next = ST_SQRT;
            ST_SQRT:     if (sqrt_done) state_next = ST_OUT;
            ST_OUT:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        mem_we     = 1'b0;
        mem_waddr  = total_reg[AW-1:0];
        mem_wdata  = id_reg;
        mem_raddr  = scan_reg[AW-1:0];
        div_start  = 1'b0;
        div_dvd    = rows_dvd;
        mul_start  = 1'b0;
        mul_a      = MUL_W'(space);
        mul_b      = '0;
        sqrt_start = 1'b0;
        unique case (state_reg)
            ST_DECIDE:   mem_we = add_ok;
            ST_SHIFT_RD: mem_raddr = sh_inc[AW-1:0];
            ST_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = sh_reg[AW-1:0];
                mem_wdata = rd_data_reg;
            end
            ST_ROWS:     div_start = !div_busy && !div_done;
            ST_COL:
            begin
                div_start = !div_busy && !div_done;
                div_dvd   = DW'(idx_reg);
            end
            ST_MUL_X:
            begin
                mul_start = !mul_busy && !mul_done;
                mul_b     = MUL_W'(kx_abs);
            end
            ST_MUL_Y:
            begin
                mul_start = !mul_busy && !mul_done;
                mul_b     = MUL_W'(ky_abs);
            end
            ST_MUL_W:
            begin
                mul_start = !mul_busy && !mul_done;
                mul_b     = (total_reg == '0) ? '0 : (MUL_W'(rows_reg) - MUL_W'(1));
            end
            ST_MUL_H:
            begin
                mul_start = !mul_busy && !mul_done;
                mul_b     = MUL_W'(p_eff) - MUL_W'(1);
            end
            ST_MUL_WW:
            begin
                mul_start = !mul_busy && !mul_done;
                mul_a     = w_reg;
                mul_b     = w_reg;
            end
            ST_MUL_HH:
            begin
                mul_start = !mul_busy && !mul_done;
                mul_a     = h_reg;
                mul_b     = h_reg;
            end
            ST_SQRT:     sqrt_start = !sqrt_busy && !sqrt_done;
            default:     mem_we = 1'b0;
        endcase
    end

    assign req.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            diam_reg      <= '0;
            apr_reg       <= APR_RESET;
            gap_reg       <= GAP_RESET;
            cmp_v_reg     <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_AGENTS_PER_ROW: apr_reg <= cfg_data[APR_W-1:0];
                    CFG_AGENT_GAP:      gap_reg <= cfg_data[GAP_W-1:0];
                    default:            apr_reg <= apr_reg;
                endcase
            end
            if (accept)
            begin
                cmp_v_reg <= 1'b0;
                found_reg <= 1'b0;
            end
            else if (state_reg == ST_SEARCH)
            begin
                cmp_v_reg <= issue && !hit;
                if (hit)
                    found_reg <= 1'b1;
            end
            if ((state_reg == ST_DECIDE) && add_ok)
            begin
                total_reg <= total_reg + CW'(1);
                if (rad2 > diam_reg)
                    diam_reg <= rad2;
            end
            if ((state_reg == ST_SHIFT_RD) && !sh_more)
                total_reg <= total_reg - CW'(1);
            if ((state_reg == ST_OUT) && out_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.operation;
            id_reg   <= req.agent_id;
            rad_reg  <= req.agent_radius;
            scan_reg <= '0;
        end
        if ((state_reg == ST_SEARCH) && issue)
        begin
            scan_reg     <= scan_reg + CW'(1);
            cmp_addr_reg <= scan_reg[AW-1:0];
        end
        if ((state_reg == ST_SEARCH) && hit)
            idx_reg <= cmp_addr_reg;
        if (state_reg == ST_DECIDE)
        begin
            status_reg <= decide_status;
            sh_reg     <= CW'(idx_reg);
            px_reg     <= '0;
            py_reg     <= '0;
        end
        if (state_reg == ST_SHIFT_WR)
            sh_reg <= sh_inc[CW-1:0];
        if ((state_reg == ST_ROWS) && div_done)
            rows_reg <= div_q[CW-1:0];
        if ((state_reg == ST_COL) && div_done)
        begin
            col_reg     <= div_q[CW-1:0];
            row_rem_reg <= div_rem;
        end
        if (mul_done)
        begin
            unique case (state_reg)
                ST_MUL_X:  px_reg  <= sat_pos(kx[KW-1], mul_prod);
                ST_MUL_Y:  py_reg  <= sat_pos(ky[YW-1], mul_prod);
                ST_MUL_W:  w_reg   <= (total_reg == '0) ? '0
                                      : (MUL_W'(diam_reg) + mul_prod[MUL_W-1:0]);
                ST_MUL_H:  h_reg   <= MUL_W'(diam_reg) + mul_prod[MUL_W-1:0];
                ST_MUL_WW: sq_reg  <= mul_prod;
                ST_MUL_HH: sum_reg <= sq_reg + mul_prod;
                default:   sq_reg  <= sq_reg;
            endcase
        end
        if ((state_reg == ST_SQRT) && sqrt_done)
            gr_reg <= (sqrt_root > MUL_W'(GR_MAX_C)) ? GR_MAX_C : sqrt_root[GR_W-1:0];
        if ((state_reg == ST_OUT) && out_free)
        begin
            rsp_status_reg <= status_reg;
            rsp_px_reg     <= px_reg;
            rsp_py_reg     <= py_reg;
            rsp_gr_reg     <= gr_reg;
            rsp_cnt_reg    <= CNT_W'(total_reg);
        end
    end

    gfst_div #(.DW(DW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (p_eff),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_rem)
    );

    gfst_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_prod)
    );

    gfst_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (sum_reg),
        .busy  (sqrt_busy),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.pos_x        = $signed(rsp_px_reg);
    assign rsp.pos_y        = $signed(rsp_py_reg);
    assign rsp.group_radius = rsp_gr_reg;
    assign rsp.member_count = rsp_cnt_reg;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CW'(MAX_MEMBERS))
        else $error("member total above table depth");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_DECIDE || state_reg == ST_SHIFT_WR))
        else $error("member RAM written outside add or shift");

    a_diam_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> diam_reg >= $past(diam_reg))
        else $error("largest diameter shrank");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_SEARCH)
        else $error("accepted transaction did not start a search");

    a_rsp_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("response raised outside output state");

endmodule

@@ rtl/gfst_mul.sv @@
// Iterative unsigned multiplier, one 4-bit digit of b per cycle.
// Depends on gfst_pkg.
module gfst_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gfst_pkg::MUL_W-1:0]    a,
    input  logic [gfst_pkg::MUL_W-1:0]    b,
    output logic                          busy,
    output logic                          done,
    output logic [gfst_pkg::PROD_W-1:0]   product
);
    import gfst_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [PROD_W-1:0]   a_reg;
    logic [MUL_W-1:0]    b_reg;
    logic [PROD_W-1:0]   acc_reg;
    logic [PROD_W-1:0]   partial;
    logic [MUL_W-1:0]    b_rest;
    logic                launch;

    assign launch  = start && !busy_reg;
    assign partial = a_reg * b_reg[DIG_W-1:0];
    assign b_rest  = b_reg >> DIG_W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (b_rest == '0);
            if (launch)
                busy_reg <= 1'b1;
            else if (busy_reg && (b_rest == '0))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            a_reg   <= PROD_W'(a);
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + partial;
            a_reg   <= a_reg << DIG_W;
            b_reg   <= b_rest;
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ rtl/gfst_div.sv @@
// Restoring divider by the row length, one quotient bit per cycle.
// Depends on gfst_pkg.
module gfst_div #(
    parameter int DW = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [DW-1:0]                dividend,
    input  logic [gfst_pkg::APR_W-1:0]   divisor,
    output logic                         busy,
    output logic                         done,
    output logic [DW-1:0]                quotient,
    output logic [gfst_pkg::APR_W-1:0]   remainder
);
    import gfst_pkg::*;

    localparam int STEP_W = $clog2(DW + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic [DW-1:0]       q_reg;
    logic [APR_W-1:0]    rem_reg;
    logic [APR_W-1:0]    dvsr_reg;
    logic [APR_W:0]      rem_t;
    logic [APR_W:0]      diff;
    logic                ge;
    logic                launch;

    assign launch = start && !busy_reg;
    assign rem_t  = {rem_reg, q_reg[DW-1]};
    assign ge     = rem_t >= {1'b0, dvsr_reg};
    assign diff   = rem_t - {1'b0, dvsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == STEP_W'(1));
            if (launch)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            q_reg    <= dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DW-2:0], ge};
            rem_reg <= ge ? diff[APR_W-1:0] : rem_t[APR_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/gfst_isqrt.sv @@
// Integer square root (round down), one result bit per cycle.
// Depends on gfst_pkg.
module gfst_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gfst_pkg::PROD_W-1:0]   value,
    output logic                          busy,
    output logic                          done,
    output logic [gfst_pkg::MUL_W-1:0]    root
);
    import gfst_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [PROD_W-1:0]   v_reg;
    logic [PROD_W-1:0]   res_reg;
    logic [PROD_W-1:0]   bit_reg;
    logic [PROD_W-1:0]   trial;
    logic                ge;
    logic                launch;

    assign launch = start && !busy_reg;
    assign trial  = res_reg + bit_reg;
    assign ge     = v_reg >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && bit_reg[0];
            if (launch)
                busy_reg <= 1'b1;
            else if (busy_reg && bit_reg[0])
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            v_reg   <= value;
            res_reg <= '0;
            bit_reg <= PROD_W'(1) << (PROD_W - 2);
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = res_reg[MUL_W-1:0];

endmodule
